// ===== rtl/round_robin_slot_selector_macros.svh =====
// Assertion macros used by the port-level checker
`ifndef ROUND_ROBIN_SLOT_SELECTOR_MACROS_SVH
`define ROUND_ROBIN_SLOT_SELECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RRSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RRSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rrss_pkg.sv =====
// Package: constants, status codes and controller/datapath interface types
`default_nettype none
package rrss_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = 6;
    localparam int CNT_W   = 7;
    localparam int CTR_W   = 32;
    localparam int DIV_W   = 5;   // log2 of CTR_W
    localparam int LANES   = 8;   // slots checked per scan cycle
    localparam int MASK_W  = 64;
    localparam int STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_CHOSEN  = 2'd0;
    localparam logic [STAT_W-1:0] ST_DEFAULT = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE    = 2'd2;

    typedef struct packed {
        logic capture;
        logic div_step;
        logic scan_init;
        logic scan_step;
        logic load_out;
    } rrss_cmd_t;

    typedef struct packed {
        logic zero_count;
        logic div_last;
        logic scan_done;
    } rrss_sts_t;

endpackage
`default_nettype wire

// ===== rtl/rrss_dp.sv =====
// Datapath: config register, rotation counter, serial modulo and slot scan
`default_nettype none
module rrss_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rrss_pkg::CNT_W-1:0]    cfg_wr_data,
    input  wire logic [rrss_pkg::MASK_W-1:0]   ready_mask,
    input  wire rrss_pkg::rrss_cmd_t           cmd,
    output rrss_pkg::rrss_sts_t                sts,
    output logic [rrss_pkg::STAT_W-1:0]        status,
    output logic [rrss_pkg::SLOT_W-1:0]        chosen_slot
);

    logic [rrss_pkg::CNT_W-1:0]  active_count_reg;
    logic [rrss_pkg::CTR_W-1:0]  counter_reg, counter_next;
    logic [rrss_pkg::CNT_W-1:0]  n_eff;

    logic [rrss_pkg::MASK_W-1:0] mask_reg;
    logic [rrss_pkg::CNT_W-1:0]  n_reg;
    logic [rrss_pkg::CTR_W-1:0]  quot_reg, quot_next;
    logic [rrss_pkg::CNT_W-1:0]  rem_reg, rem_next;
    logic [rrss_pkg::DIV_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [rrss_pkg::CNT_W:0]    rem_shift;

    logic [rrss_pkg::CNT_W-1:0]  cur_reg, cur_next;
    logic [rrss_pkg::CNT_W-1:0]  left_reg, left_next;
    logic                        found_reg, found_next;
    logic [rrss_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [rrss_pkg::CNT_W:0]    cur_adv;

    logic [rrss_pkg::STAT_W-1:0] status_reg, status_next;
    logic [rrss_pkg::SLOT_W-1:0] chosen_reg, chosen_next;

    // counts above SLOTS saturate
    assign n_eff = (active_count_reg > rrss_pkg::CNT_W'(rrss_pkg::SLOTS))
                 ? rrss_pkg::CNT_W'(rrss_pkg::SLOTS) : active_count_reg;

    assign sts.zero_count = (n_eff == '0);
    assign sts.div_last   = (div_cnt_reg == '1);
    assign sts.scan_done  = found_reg || (left_reg == '0);

    assign status      = status_reg;
    assign chosen_slot = chosen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_count_reg <= '0;
            counter_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                active_count_reg <= cfg_wr_data;
            end
            counter_reg <= counter_next;
        end
    end

    always_comb begin
        counter_next = counter_reg;
        if (cmd.capture && !sts.zero_count) begin
            counter_next = counter_reg + 1'b1;
        end
    end

    // restoring remainder, one counter bit per step, MSB first
    always_comb begin
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        rem_shift    = {rem_reg, quot_reg[rrss_pkg::CTR_W-1]};
        if (cmd.capture) begin
            quot_next    = counter_reg;
            rem_next     = '0;
            div_cnt_next = '0;
        end else if (cmd.div_step) begin
            quot_next    = {quot_reg[rrss_pkg::CTR_W-2:0], 1'b0};
            div_cnt_next = div_cnt_reg + 1'b1;
            if (rem_shift >= {1'b0, n_reg}) begin
                rem_next = rrss_pkg::CNT_W'(rem_shift - {1'b0, n_reg});
            end else begin
                rem_next = rrss_pkg::CNT_W'(rem_shift);
            end
        end
    end

    // scan LANES slots per cycle; lowest lane with a ready bit wins
    always_comb begin
        logic [rrss_pkg::CNT_W:0] cand;
        logic                     hit;
        logic [rrss_pkg::SLOT_W-1:0] hit_slot;
        cur_next  = cur_reg;
        left_next = left_reg;
        found_next = found_reg;
        slot_next  = slot_reg;
        hit      = 1'b0;
        hit_slot = '0;
        cand     = '0;
        cur_adv  = {1'b0, cur_reg} + (rrss_pkg::CNT_W + 1)'(rrss_pkg::LANES);
        if (cur_adv >= {1'b0, n_reg}) begin
            cur_adv = cur_adv - {1'b0, n_reg};
        end
        for (int k = rrss_pkg::LANES - 1; k >= 0; k--) begin
            cand = {1'b0, cur_reg} + (rrss_pkg::CNT_W + 1)'(k);
            if (cand >= {1'b0, n_reg}) begin
                cand = cand - {1'b0, n_reg};
            end
            if ((left_reg > rrss_pkg::CNT_W'(k)) && mask_reg[cand[rrss_pkg::SLOT_W-1:0]]) begin
                hit      = 1'b1;
                hit_slot = cand[rrss_pkg::SLOT_W-1:0];
            end
        end
        if (cmd.scan_init) begin
            cur_next   = rem_reg;
            left_next  = n_reg;
            found_next = 1'b0;
            slot_next  = '0;
        end else if (cmd.scan_step) begin
            found_next = hit;
            slot_next  = hit_slot;
            cur_next   = rrss_pkg::CNT_W'(cur_adv);
            if (left_reg > rrss_pkg::CNT_W'(rrss_pkg::LANES)) begin
                left_next = left_reg - rrss_pkg::CNT_W'(rrss_pkg::LANES);
            end else begin
                left_next = '0;
            end
        end
    end

    always_comb begin
        status_next = status_reg;
        chosen_next = chosen_reg;
        if (cmd.load_out) begin
            if (n_reg == '0) begin
                status_next = rrss_pkg::ST_DEFAULT;
                chosen_next = '0;
            end else if (found_reg) begin
                status_next = rrss_pkg::ST_CHOSEN;
                chosen_next = slot_reg;
            end else begin
                status_next = rrss_pkg::ST_NONE;
                chosen_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mask_reg <= ready_mask;
            n_reg    <= n_eff;
        end
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        cur_reg     <= cur_next;
        left_reg    <= left_next;
        found_reg   <= found_next;
        slot_reg    <= slot_next;
        status_reg  <= status_next;
        chosen_reg  <= chosen_next;
    end

endmodule
`default_nettype wire

// ===== rtl/rrss_ctrl.sv =====
// Controller: sequences capture, modulo, scan and result handoff
`default_nettype none
module rrss_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire rrss_pkg::rrss_sts_t  sts,
    output rrss_pkg::rrss_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SINIT,
        S_SCAN,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = sts.zero_count ? S_FIN : S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_SINIT;
                end
            end
            S_SINIT: begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                if (sts.scan_done) begin
                    state_next = S_FIN;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/round_robin_slot_selector.sv =====
// Round-robin slot selector with skip of slots that are not ready.
//
// Input stream s_*: one transfer per request, s_tdata = ready_mask (bit i = slot i ready).
// Output stream m_*: one transfer per request, m_tdata = {chosen_slot, status}.
// Config: cfg_wr_en/cfg_wr_data write active_count (0 = default handling, >64 saturates).
// Write config only while the block is idle.
//
// Sequence: with a nonzero count, bit-serial remainder (counter mod count), a scan
// setup step, scan steps (8 slots per cycle) until a hit or the last slot, a step to see
// the scan end and the result load that raises m_tvalid. Zero count: accept, then load.
// One request is in work at a time; s_tready rises again once the result is loaded
// into the output register, so the next request runs while that result waits.
// Reset clears the rotation counter, active_count and m_tvalid; s_tready is high after it.
// When the receiver stalls the output register holds its transfer and the next result
// waits in the controller until the register frees up.
`default_nettype none
module round_robin_slot_selector (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [rrss_pkg::CNT_W-1:0]   cfg_wr_data,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [rrss_pkg::MASK_W-1:0]  s_tdata,   // [63:0] ready_mask
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [7:0]                        m_tdata    // [1:0] status, [7:2] chosen_slot
);

    rrss_pkg::rrss_cmd_t         cmd;
    rrss_pkg::rrss_sts_t         sts;
    logic [rrss_pkg::STAT_W-1:0] status;
    logic [rrss_pkg::SLOT_W-1:0] chosen_slot;

    rrss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrss_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ready_mask  (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .status      (status),
        .chosen_slot (chosen_slot)
    );

    assign m_tdata = {chosen_slot, status};

endmodule
`default_nettype wire

// ===== rtl/rrss_checker.sv =====
// Port-level checker for the slot selector, bound to the top level
`default_nettype none
`include "round_robin_slot_selector_macros.svh"
module rrss_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    logic [rrss_pkg::STAT_W-1:0] out_status;
    logic [rrss_pkg::SLOT_W-1:0] out_slot;
    logic [8:0]                  out_word;
    logic                        out_stall;
    logic                        status_ok;
    logic                        no_pick;
    logic                        in_xfer;

    assign out_status = m_tdata[1:0];
    assign out_slot   = m_tdata[7:2];
    assign out_word   = {m_tvalid, m_tdata};
    assign out_stall  = m_tvalid && !m_tready;
    assign status_ok  = (out_status == rrss_pkg::ST_CHOSEN)
                     || (out_status == rrss_pkg::ST_DEFAULT)
                     || (out_status == rrss_pkg::ST_NONE);
    assign no_pick    = m_tvalid && (out_status != rrss_pkg::ST_CHOSEN);
    assign in_xfer    = s_tvalid && s_tready;

    `RRSS_ASSERT_NXT(a_hold, aclk, aresetn, out_stall, $stable(out_word), "stalled output moved")

    `RRSS_ASSERT_IMP(a_status, aclk, aresetn, m_tvalid, status_ok, "bad status code")

    `RRSS_ASSERT_IMP(a_slot_zero, aclk, aresetn, no_pick, out_slot == '0, "stray slot index")

    `RRSS_ASSERT_NXT(a_one_in_work, aclk, aresetn, in_xfer, !s_tready, "input taken while busy")

endmodule

bind round_robin_slot_selector rrss_checker u_rrss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
